// ===== src/melody_note_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the melody note sequencer
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MELODY_NOTE_SEQUENCER_ASSERT_SVH
`define MELODY_NOTE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("melody_note_sequencer: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MNS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("melody_note_sequencer: next-cycle check failed");

`endif

// ===== src/mns_pkg.sv =====
// ----------------------------------------------------------------------------
// Melody note sequencer package
// Table size, field widths, item types and codes shared by all modules.
// ----------------------------------------------------------------------------
package mns_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned POS_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned NOW_W  = 32;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned DIV_W  = 8;
  localparam int unsigned LEN_W  = 10;

  // Note length numerator in milliseconds.
  localparam logic [LEN_W-1:0] NOTE_MS_NUM = LEN_W'(1000);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_SILENCE = 2'd1,
    ACT_TONE    = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [NOW_W-1:0]  now_ms;
    logic [3:0]        entry_index;
    logic [FREQ_W-1:0] entry_note;
    logic [DIV_W-1:0]  entry_divisor;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [FREQ_W-1:0] tone_freq;
    logic [LEN_W-1:0]  tone_ms;
    logic              playing;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/mns_divider.sv =====
// ----------------------------------------------------------------------------
// Note length divider
// Restoring divider that forms 1000 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mns_divider import mns_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(LEN_W + 1);

  logic             active_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] dsr_q;
  logic [DIV_W-1:0] rem_q;
  logic [LEN_W-1:0] quo_q;

  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] rem_diff;
  logic           ge;

  assign rem_sh   = {rem_q, quo_q[LEN_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr_q};
  assign ge       = (rem_sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      dsr_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
        dsr_q    <= req_i.divisor;
        rem_q    <= '0;
        // The dividend shifts out of the top while quotient bits shift in.
        quo_q    <= NOTE_MS_NUM;
      end else if (active_q) begin
        rem_q <= ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quo_q <= {quo_q[LEN_W-2:0], ge};
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(LEN_W - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== src/mns_seq.sv =====
// ----------------------------------------------------------------------------
// Melody note sequencer control
// Holds the note tables and play state and steps each item through a small
// sequencer that uses the divider for note lengths.
// ----------------------------------------------------------------------------
module mns_seq import mns_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_item_t res_o,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CMP,
    S_LOAD,
    S_DIV,
    S_RESP
  } state_e;

  state_e                   state_q;
  in_item_t                 req_q;
  logic [POS_W-1:0]         pos_q;
  logic                     first_q;
  logic                     adv_q;
  logic [NOW_W-1:0]         start_q;
  logic [NOW_W-1:0]         elapsed_q;
  logic [FREQ_W-1:0]        cur_freq_q;
  logic [LEN_W-1:0]         cur_len_q;
  logic                     busy_q;
  logic                     div_start_q;
  logic [DIV_W-1:0]         div_dsr_q;
  out_item_t                res_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [FREQ_W-1:0]        note_q [TABLE_ENTRIES];
  logic [DIV_W-1:0]         dsr_tab_q [TABLE_ENTRIES];

  logic              pos_in_range;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_hit;
  logic [FREQ_W-1:0] rd_note;
  logic [DIV_W-1:0]  rd_div;
  logic              melody_present;
  logic              idx_ok;
  logic [IDX_W-1:0]  wr_idx;
  logic              tbl_we;
  logic [35:0]       elapsed_x10;
  logic [35:0]       length_x13;
  logic              expired;

  // Table read at the current position; entries never written read as zero.
  assign pos_in_range   = (32'(pos_q) < 32'(TABLE_ENTRIES));
  assign rd_idx         = pos_q[IDX_W-1:0];
  assign rd_hit         = pos_in_range && valid_q[rd_idx];
  assign rd_note        = rd_hit ? note_q[rd_idx] : '0;
  assign rd_div         = rd_hit ? dsr_tab_q[rd_idx] : '0;
  assign melody_present = valid_q[0] && (dsr_tab_q[0] != '0);

  assign idx_ok = (32'(req_q.entry_index) < 32'(TABLE_ENTRIES));
  assign wr_idx = IDX_W'(req_q.entry_index);
  assign tbl_we = (state_q == S_DECODE) && (op_e'(req_q.op) == OP_LOAD) &&
                  !busy_q && idx_ok;

  // elapsed * 10 > length * 13 decides that the current note has run out.
  assign elapsed_x10 = {1'b0, elapsed_q, 3'b000} + {3'b000, elapsed_q, 1'b0};
  assign length_x13  = 36'(cur_len_q) * 36'd13;
  assign expired     = (elapsed_x10 > length_x13);

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      note_q[wr_idx]    <= req_q.entry_note;
      dsr_tab_q[wr_idx] <= req_q.entry_divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      pos_q       <= '0;
      first_q     <= 1'b0;
      adv_q       <= 1'b0;
      start_q     <= '0;
      elapsed_q   <= '0;
      cur_freq_q  <= '0;
      cur_len_q   <= '0;
      busy_q      <= 1'b0;
      div_start_q <= 1'b0;
      div_dsr_q   <= '0;
      res_q       <= '0;
      valid_q     <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (tbl_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_item_i;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_q   <= '{action: ACT_NONE, tone_freq: '0, tone_ms: '0, playing: busy_q};
          state_q <= S_RESP;
          case (op_e'(req_q.op))
            OP_TICK: begin
              busy_q        <= 1'b0;
              res_q.playing <= 1'b0;
              if (!melody_present) begin
                // Empty melody: nothing to do.
              end else if (!pos_in_range) begin
                // Ran past the last entry: forget the melody.
                valid_q      <= '0;
                pos_q        <= '0;
                first_q      <= 1'b0;
                cur_freq_q   <= '0;
                cur_len_q    <= '0;
                res_q.action <= ACT_SILENCE;
              end else begin
                busy_q        <= 1'b1;
                res_q.playing <= 1'b1;
                if (!first_q) begin
                  start_q <= req_q.now_ms;
                  first_q <= 1'b1;
                  adv_q   <= 1'b0;
                  state_q <= S_LOAD;
                end else begin
                  elapsed_q <= req_q.now_ms - start_q;
                  state_q   <= S_CMP;
                end
              end
            end
            OP_LOAD: begin
            end
            OP_RESTART: begin
              if (!busy_q) begin
                pos_q        <= '0;
                first_q      <= 1'b0;
                res_q.action <= ACT_SILENCE;
              end
            end
            default: begin
            end
          endcase
        end
        S_CMP: begin
          if (expired) begin
            start_q <= req_q.now_ms;
            pos_q   <= pos_q + POS_W'(1);
            adv_q   <= 1'b1;
            state_q <= S_LOAD;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_LOAD: begin
          cur_freq_q <= rd_note;
          if (rd_div == '0) begin
            cur_len_q <= '0;
            state_q   <= S_RESP;
            // An end note reached by advancing silences; a first note still
            // starts, with zero length.
            if (adv_q) begin
              res_q.action <= ACT_SILENCE;
            end else begin
              res_q.action    <= ACT_TONE;
              res_q.tone_freq <= rd_note;
            end
          end else begin
            div_start_q <= 1'b1;
            div_dsr_q   <= rd_div;
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp_i.done) begin
            cur_len_q       <= div_rsp_i.quotient;
            res_q.action    <= ACT_TONE;
            res_q.tone_freq <= cur_freq_q;
            res_q.tone_ms   <= div_rsp_i.quotient;
            state_q         <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_RESP);
  assign res_o             = res_q;
  assign div_req_o.start   = div_start_q;
  assign div_req_o.divisor = div_dsr_q;

endmodule

// ===== src/melody_note_sequencer.sv =====
// ----------------------------------------------------------------------------
// Melody note sequencer
// Usage: one input item per handshake on in_valid_i / in_ready_o carries an
// op (tick with the millisecond time, table load, or restart). Each item gives
// exactly one result item on out_valid_o / out_ready_i with the speaker
// action, the tone frequency and length, and the playing flag.
// Each item is decoded first. A load, restart, unknown op, empty-table or
// run-out tick then goes straight to the result; a tick that leaves the note
// playing first compares the elapsed time, and a tick that advances onto an
// end note also reads the table. A tick that starts a tone reads the table and
// starts the divider, which forms 1000 / divisor one quotient bit per cycle (10
// steps); it compares the elapsed time first when it ends the previous note.
// The block takes one item at a time; it does not accept a new item until
// the previous result has reached the output register.
// in_ready_o is low from accept until the result has moved to the output
// register; the next item may then be accepted while that result still waits.
// A stalled receiver holds the result in the output register; once that
// register and the internal result are both full, input stalls too.
// Reset empties the note table, stops play and leaves no result pending.
// ----------------------------------------------------------------------------
`include "melody_note_sequencer_assert.svh"

module melody_note_sequencer import mns_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      res_valid;
  logic      res_ready;
  out_item_t res;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      out_valid_q;
  out_item_t out_item_q;

  mns_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  mns_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register decouples the sequencer from a stalled receiver.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
        out_item_q  <= res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `MNS_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `MNS_ASSERT_IMP(a_tone_len_range, out_valid_o && (out_item_o.action == ACT_TONE),
                  out_item_o.tone_ms <= NOTE_MS_NUM)
  `MNS_ASSERT_IMP(a_no_tone_fields, out_valid_o && (out_item_o.action != ACT_TONE),
                  (out_item_o.tone_freq == '0) && (out_item_o.tone_ms == '0))
  `MNS_ASSERT_IMP(a_divider_idle_at_start, div_req.start, !div_rsp.done)

endmodule
